>>> rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion core.
`default_nettype none
package rmq_pkg;
   localparam int ELEM_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;
   localparam int MAG_W          = 30;
   localparam int SQ_W           = 2 * MAG_W;
   localparam int SUM_W          = SQ_W + 2;
   localparam int ROOT_W         = SUM_W / 2;

   typedef logic [3:0][MAG_W-1:0] mag4_type;

   typedef struct packed {
      logic [3:0] neg;
      logic       degen;
   } side_type;
endpackage
`default_nettype wire

>>> rtl/rmq_front.sv
// Branch selection, magnitudes and left-justifying normalization pipeline.
`default_nettype none
module rmq_front #(
   parameter int ELEM_WIDTH = rmq_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [ELEM_WIDTH-1:0] e00,
   input  logic signed [ELEM_WIDTH-1:0] e01,
   input  logic signed [ELEM_WIDTH-1:0] e02,
   input  logic signed [ELEM_WIDTH-1:0] e10,
   input  logic signed [ELEM_WIDTH-1:0] e11,
   input  logic signed [ELEM_WIDTH-1:0] e12,
   input  logic signed [ELEM_WIDTH-1:0] e20,
   input  logic signed [ELEM_WIDTH-1:0] e21,
   input  logic signed [ELEM_WIDTH-1:0] e22,
   output logic                         out_valid,
   output rmq_pkg::mag4_type            out_mag,
   output rmq_pkg::side_type            out_side
);
   localparam int VW    = ((ELEM_WIDTH > FRAC_BITS + 1) ? ELEM_WIDTH : FRAC_BITS + 1) + 3;
   localparam int NW    = (VW - 1 > rmq_pkg::MAG_W) ? VW - 1 : rmq_pkg::MAG_W;
   localparam int NSTEP = $clog2(NW);
   localparam logic signed [VW-1:0] ONE_V = VW'(64'd1 << FRAC_BITS);

   typedef enum logic [1:0] {BR_TRACE, BR_X, BR_Y, BR_Z} branch_type;

   logic signed [VW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, tr;
   assign a00 = VW'(e00);
   assign a01 = VW'(e01);
   assign a02 = VW'(e02);
   assign a10 = VW'(e10);
   assign a11 = VW'(e11);
   assign a12 = VW'(e12);
   assign a20 = VW'(e20);
   assign a21 = VW'(e21);
   assign a22 = VW'(e22);
   assign tr  = a00 + a11 + a22;

   // stage 1: sums, differences, branch choice
   logic                 s1_valid_ff;
   branch_type           br_ff, br_in;
   logic signed [VW-1:0] d0_ff, d1_ff, d2_ff, s0_ff, s1_ff, s2_ff;
   logic signed [VW-1:0] tt_ff [0:3];

   always_comb begin
      priority if (tr > 0)                    br_in = BR_TRACE;
      else if ((a00 > a11) && (a00 > a22))    br_in = BR_X;
      else if (a11 > a22)                     br_in = BR_Y;
      else                                    br_in = BR_Z;
   end

   always_ff @(posedge clock) begin
      br_ff    <= br_in;
      d0_ff    <= a12 - a21;
      d1_ff    <= a20 - a02;
      d2_ff    <= a01 - a10;
      s0_ff    <= a10 + a01;
      s1_ff    <= a20 + a02;
      s2_ff    <= a21 + a12;
      tt_ff[0] <= ONE_V + tr;
      tt_ff[1] <= ONE_V + a00 - a11 - a22;
      tt_ff[2] <= ONE_V + a11 - a00 - a22;
      tt_ff[3] <= ONE_V + a22 - a11 - a00;
   end

   // stage 2: pick the branch vector, split sign and magnitude
   logic signed [VW-1:0] v [0:3];
   logic signed [VW-1:0] t;
   logic signed [VW-1:0] mg [0:3];
   logic [NW-1:0]        nrm_ff [0:NSTEP][0:3];
   logic [NW-1:0]        nrm_in [1:NSTEP][0:3];
   rmq_pkg::side_type    side_ff [0:NSTEP];
   rmq_pkg::side_type    side0_in;
   logic [NSTEP:0]       vld_ff;

   always_comb begin
      unique case (br_ff)
         BR_TRACE: begin
            v[0] = d0_ff; v[1] = d1_ff; v[2] = d2_ff; v[3] = tt_ff[0]; t = tt_ff[0];
         end
         BR_X: begin
            v[0] = tt_ff[1]; v[1] = s0_ff; v[2] = s1_ff; v[3] = d0_ff; t = tt_ff[1];
         end
         BR_Y: begin
            v[0] = s0_ff; v[1] = tt_ff[2]; v[2] = s2_ff; v[3] = d1_ff; t = tt_ff[2];
         end
         BR_Z: begin
            v[0] = s1_ff; v[1] = s2_ff; v[2] = tt_ff[3]; v[3] = d2_ff; t = tt_ff[3];
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         side0_in.neg[i] = v[i][VW-1];
         mg[i]           = v[i][VW-1] ? -v[i] : v[i];
      end
      side0_in.degen = t[VW-1] || (t == '0);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) nrm_ff[0][i] <= NW'(mg[i][VW-2:0]);
      side_ff[0] <= side0_in;
   end

   // stages 3..: shift all four left by halving amounts until the top bit is set
   for (genvar k = 0; k < NSTEP; k++) begin : g_norm
      localparam int SH = 1 << (NSTEP - 1 - k);
      logic [NW-1:0] orv;
      logic          hit;
      always_comb begin
         orv = '0;
         for (int i = 0; i < 4; i++) orv = orv | nrm_ff[k][i];
         hit = (orv[NW-1 -: SH] == '0);
         for (int i = 0; i < 4; i++) nrm_in[k+1][i] = hit ? (nrm_ff[k][i] << SH) : nrm_ff[k][i];
      end
      always_ff @(posedge clock) begin
         for (int i = 0; i < 4; i++) nrm_ff[k+1][i] <= nrm_in[k+1][i];
         side_ff[k+1] <= side_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         vld_ff      <= '0;
      end else begin
         s1_valid_ff <= in_valid;
         vld_ff      <= {vld_ff[NSTEP-1:0], s1_valid_ff};
      end
   end

   assign out_valid = vld_ff[NSTEP];
   assign out_side  = side_ff[NSTEP];
   always_comb begin
      for (int i = 0; i < 4; i++) out_mag[i] = nrm_ff[NSTEP][i][NW-1 -: rmq_pkg::MAG_W];
   end
endmodule
`default_nettype wire

>>> rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rmq_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [rmq_pkg::SUM_W-1:0]    in_sum,
   input  rmq_pkg::mag4_type            in_mag,
   input  rmq_pkg::side_type            in_side,
   output logic                         out_valid,
   output logic [rmq_pkg::ROOT_W-1:0]   out_root,
   output rmq_pkg::mag4_type            out_mag,
   output rmq_pkg::side_type            out_side
);
   localparam int RW = rmq_pkg::ROOT_W;
   localparam int CW = RW + 3;

   logic [rmq_pkg::SUM_W-1:0] rad_ff  [0:RW];
   logic [CW-1:0]             rem_ff  [0:RW];
   logic [RW-1:0]             root_ff [0:RW];
   rmq_pkg::mag4_type         mag_ff  [0:RW];
   rmq_pkg::side_type         side_ff [0:RW];
   logic [RW-1:0]             vld_ff;

   assign rad_ff[0]  = in_sum;
   assign rem_ff[0]  = '0;
   assign root_ff[0] = '0;
   assign mag_ff[0]  = in_mag;
   assign side_ff[0] = in_side;

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic [CW-1:0] cur, trial;
      logic          ge;
      always_comb begin
         cur   = {rem_ff[k][CW-3:0], rad_ff[k][rmq_pkg::SUM_W-1 -: 2]};
         trial = {1'b0, root_ff[k], 2'b01};
         ge    = (cur >= trial);
      end
      always_ff @(posedge clock) begin
         rad_ff[k+1]  <= rad_ff[k] << 2;
         rem_ff[k+1]  <= ge ? (cur - trial) : cur;
         root_ff[k+1] <= {root_ff[k][RW-2:0], ge};
         mag_ff[k+1]  <= mag_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   // vld_ff[k] travels with root_ff[k+1]
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[RW-2:0], in_valid};
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW];
   assign out_mag   = mag_ff[RW];
   assign out_side  = side_ff[RW];
endmodule
`default_nettype wire

>>> rtl/rmq_div.sv
// Four-lane pipelined restoring divider with half-divisor rounding.
`default_nettype none
module rmq_div #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  rmq_pkg::mag4_type           in_mag,
   input  logic [rmq_pkg::ROOT_W-1:0]  in_len,
   input  rmq_pkg::side_type           in_side,
   output logic                        out_valid,
   output logic [3:0][FRAC_BITS:0]     out_q,
   output rmq_pkg::side_type           out_side
);
   localparam int RW   = rmq_pkg::ROOT_W;
   localparam int NUMW = FRAC_BITS + RW;
   localparam int NST  = FRAC_BITS + 1;

   logic [RW-1:0]        rem_ff  [0:NST][0:3];
   logic [FRAC_BITS:0]   qb_ff   [0:NST][0:3];
   logic [RW-1:0]        len_ff  [0:NST];
   rmq_pkg::side_type    side_ff [0:NST];
   logic [NST:0]         vld_ff;
   logic [NUMW-1:0]      num [0:3];

   // numerator = mag * ONE + len / 2; the high part is already below len
   always_comb begin
      for (int i = 0; i < 4; i++)
         num[i] = (NUMW'(in_mag[i]) << FRAC_BITS) + NUMW'(in_len >> 1);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         rem_ff[0][i] <= RW'(num[i][NUMW-1:FRAC_BITS+1]);
         qb_ff[0][i]  <= num[i][FRAC_BITS:0];
      end
      len_ff[0]  <= in_len;
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < NST; k++) begin : g_step
      logic [RW:0] cur [0:3];
      logic [RW:0] dif [0:3];
      logic        ge  [0:3];
      always_comb begin
         for (int i = 0; i < 4; i++) begin
            cur[i] = {rem_ff[k][i], qb_ff[k][i][FRAC_BITS]};
            dif[i] = cur[i] - {1'b0, len_ff[k]};
            ge[i]  = (cur[i] >= {1'b0, len_ff[k]});
         end
      end
      always_ff @(posedge clock) begin
         for (int i = 0; i < 4; i++) begin
            rem_ff[k+1][i] <= ge[i] ? dif[i][RW-1:0] : cur[i][RW-1:0];
            qb_ff[k+1][i]  <= {qb_ff[k][i][FRAC_BITS-1:0], ge[i]};
         end
         len_ff[k+1]  <= len_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[NST-1:0], in_valid};
   end

   assign out_valid = vld_ff[NST];
   assign out_side  = side_ff[NST];
   always_comb begin
      for (int i = 0; i < 4; i++) out_q[i] = qb_ff[NST][i];
   end
endmodule
`default_nettype wire

>>> rtl/rotation_matrix_to_quaternion_core.sv
// Top level: rotation matrix to normalized quaternion, fully pipelined.
`default_nettype none
// Usage:
//   Drive the nine matrix elements on req_e00..req_e22 and raise start for
//   one cycle per matrix. busy is always low, so a beat is taken on every
//   clock with start high: one matrix per cycle, back to back.
//   Each result appears on rsp_qx/qy/qz/qw and rsp_degenerate for exactly
//   one cycle with rsp_valid high; results leave in the order matrices came.
//   The pipe holds two front-end branch stages and clog2(NW) normalizing
//   shift stages, NW being the wider of 30 and the magnitude width, then
//   one squaring and one summing stage, the 31-stage square root, the
//   FRAC_BITS+2 stage divider and one output stage.
//   Throughput is one result per cycle; nothing in the pipe ever stalls.
//   Synchronous reset clears only the valid bits, so all beats in flight are
//   dropped and no rsp_valid appears until new beats arrive.
//   The receiver cannot hold results off; take them when rsp_valid is high.
//   A degenerate matrix (branch root not positive) returns zeros with
//   rsp_degenerate set.
module rotation_matrix_to_quaternion_core #(
   parameter int ELEM_WIDTH = rmq_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [ELEM_WIDTH-1:0] req_e00,
   input  logic signed [ELEM_WIDTH-1:0] req_e01,
   input  logic signed [ELEM_WIDTH-1:0] req_e02,
   input  logic signed [ELEM_WIDTH-1:0] req_e10,
   input  logic signed [ELEM_WIDTH-1:0] req_e11,
   input  logic signed [ELEM_WIDTH-1:0] req_e12,
   input  logic signed [ELEM_WIDTH-1:0] req_e20,
   input  logic signed [ELEM_WIDTH-1:0] req_e21,
   input  logic signed [ELEM_WIDTH-1:0] req_e22,
   output logic                         rsp_valid,
   output logic signed [ELEM_WIDTH-1:0] rsp_qx,
   output logic signed [ELEM_WIDTH-1:0] rsp_qy,
   output logic signed [ELEM_WIDTH-1:0] rsp_qz,
   output logic signed [ELEM_WIDTH-1:0] rsp_qw,
   output logic                         rsp_degenerate
);
   localparam int MW = rmq_pkg::MAG_W;
   localparam int CW = (FRAC_BITS + 1 > ELEM_WIDTH) ? FRAC_BITS + 1 : ELEM_WIDTH;
   localparam logic [CW-1:0] POS_MAX = CW'((64'd1 << (ELEM_WIDTH - 1)) - 64'd1);

   // the pipe never stalls, so every start is a beat
   assign busy = 1'b0;

   // front end: branch, magnitudes, normalization to [2^29, 2^30)
   logic              fr_valid;
   rmq_pkg::mag4_type fr_mag;
   rmq_pkg::side_type fr_side;

   rmq_front #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .e00      (req_e00),
      .e01      (req_e01),
      .e02      (req_e02),
      .e10      (req_e10),
      .e11      (req_e11),
      .e12      (req_e12),
      .e20      (req_e20),
      .e21      (req_e21),
      .e22      (req_e22),
      .out_valid(fr_valid),
      .out_mag  (fr_mag),
      .out_side (fr_side)
   );

   // square each lane, then add the four squares
   logic [rmq_pkg::SQ_W-1:0]  sqr_ff [0:3];
   logic [rmq_pkg::SUM_W-1:0] sum_ff;
   rmq_pkg::mag4_type         sqr_mag_ff, sum_mag_ff;
   rmq_pkg::side_type         sqr_side_ff, sum_side_ff;
   logic                      sqr_valid_ff, sum_valid_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) sqr_ff[i] <= fr_mag[i] * fr_mag[i];
      sqr_mag_ff  <= fr_mag;
      sqr_side_ff <= fr_side;
      sum_ff      <= rmq_pkg::SUM_W'(sqr_ff[0]) + rmq_pkg::SUM_W'(sqr_ff[1])
                   + rmq_pkg::SUM_W'(sqr_ff[2]) + rmq_pkg::SUM_W'(sqr_ff[3]);
      sum_mag_ff  <= sqr_mag_ff;
      sum_side_ff <= sqr_side_ff;
   end

   // length of the vector
   logic                        sq_valid;
   logic [rmq_pkg::ROOT_W-1:0]  sq_root;
   rmq_pkg::mag4_type           sq_mag;
   rmq_pkg::side_type           sq_side;

   rmq_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sum_valid_ff),
      .in_sum   (sum_ff),
      .in_mag   (sum_mag_ff),
      .in_side  (sum_side_ff),
      .out_valid(sq_valid),
      .out_root (sq_root),
      .out_mag  (sq_mag),
      .out_side (sq_side)
   );

   // each component over the length, rounded half away from zero
   logic                      dv_valid;
   logic [3:0][FRAC_BITS:0]   dv_q;
   rmq_pkg::side_type         dv_side;

   rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sq_valid),
      .in_mag   (sq_mag),
      .in_len   (sq_root),
      .in_side  (sq_side),
      .out_valid(dv_valid),
      .out_q    (dv_q),
      .out_side (dv_side)
   );

   // output stage: saturate, restore sign, zero on degenerate
   logic [CW-1:0]               sat [0:3];
   logic signed [ELEM_WIDTH-1:0] res_in [0:3];
   logic signed [ELEM_WIDTH-1:0] res_ff [0:3];
   logic                        degen_ff, valid_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sat[i]    = (CW'(dv_q[i]) > POS_MAX) ? POS_MAX : CW'(dv_q[i]);
         res_in[i] = dv_side.neg[i] ? -ELEM_WIDTH'(sat[i]) : ELEM_WIDTH'(sat[i]);
         if (dv_side.degen) res_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) res_ff[i] <= res_in[i];
      degen_ff <= dv_side.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqr_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         sqr_valid_ff <= fr_valid;
         sum_valid_ff <= sqr_valid_ff;
         valid_ff     <= dv_valid;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_qx         = res_ff[0];
   assign rsp_qy         = res_ff[1];
   assign rsp_qz         = res_ff[2];
   assign rsp_qw         = res_ff[3];
   assign rsp_degenerate = degen_ff;

   // a degenerate beat carries all-zero components
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_qx == '0 && rsp_qy == '0 && rsp_qz == '0 && rsp_qw == '0))
      else $error("degenerate result with nonzero component");

   // normalization leaves the largest magnitude with its top bit set
   a_norm_top: assert property (@(posedge clock) disable iff (reset)
      (fr_valid && !fr_side.degen) |->
         ((fr_mag[0][MW-1] | fr_mag[1][MW-1] | fr_mag[2][MW-1] | fr_mag[3][MW-1]) == 1'b1))
      else $error("normalized magnitudes not left-justified");

   // the length of a normalized vector is at least 2^29
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (sq_valid && !sq_side.degen) |->
         (sq_root[rmq_pkg::ROOT_W-1:rmq_pkg::ROOT_W-2] != 2'b00))
      else $error("vector length below normalized range");
endmodule
`default_nettype wire

>>> verif/rotation_matrix_to_quaternion_core_tb.sv
// Testbench for the rotation matrix to quaternion core: random and directed matrices.
module rotation_matrix_to_quaternion_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EW        = rmq_pkg::ELEM_WIDTH_DEF;
   localparam int FB        = rmq_pkg::FRAC_BITS_DEF;
   localparam int N_RANDOM  = 1630;
   localparam int IDLE_MAX  = 12;
   // Leave generous margin after the last beat.
   localparam int DRAIN     = 200;
   localparam int STALL_MAX = 2000;
   localparam int SHOW_MAX  = 10;

   typedef logic signed [EW-1:0] elem_type;

   typedef struct {
      elem_type e [9];
   } matrix_type;

   typedef struct {
      elem_type qx, qy, qz, qw;
      logic     degen;
   } quat_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   elem_type req_e00 = '0, req_e01 = '0, req_e02 = '0;
   elem_type req_e10 = '0, req_e11 = '0, req_e12 = '0;
   elem_type req_e20 = '0, req_e21 = '0, req_e22 = '0;
   logic     rsp_valid;
   elem_type rsp_qx, rsp_qy, rsp_qz, rsp_qw;
   logic     rsp_degenerate;

   matrix_type pending_matrices[$];
   quat_type   expected_quats[$];
   int         mismatches = 0;
   int         idle_cycles = 0;
   int         quiet_cycles = 0;
   bit         stimulus_done = 1'b0;

   rotation_matrix_to_quaternion_core dut (
      .clock, .reset, .start, .busy,
      .req_e00, .req_e01, .req_e02,
      .req_e10, .req_e11, .req_e12,
      .req_e20, .req_e21, .req_e22,
      .rsp_valid, .rsp_qx, .rsp_qy, .rsp_qz, .rsp_qw, .rsp_degenerate
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Integer square root, floor.
   function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Compute the normalized quaternion of one matrix by the trace method.
   function automatic quat_type matrix_to_quat(matrix_type m);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, t;
      longint v [4];
      longint unsigned mag [4];
      bit neg [4];
      longint unsigned mx, sum, len, q;
      longint s;
      elem_type r [4];
      quat_type o;
      a00 = m.e[0]; a01 = m.e[1]; a02 = m.e[2];
      a10 = m.e[3]; a11 = m.e[4]; a12 = m.e[5];
      a20 = m.e[6]; a21 = m.e[7]; a22 = m.e[8];
      tr = a00 + a11 + a22;
      if (tr > 0) begin
         t = (64'sd1 << FB) + tr;
         v[0] = a12 - a21; v[1] = a20 - a02; v[2] = a01 - a10; v[3] = t;
      end else if (a00 > a11 && a00 > a22) begin
         t = (64'sd1 << FB) + a00 - a11 - a22;
         v[0] = t; v[1] = a10 + a01; v[2] = a20 + a02; v[3] = a12 - a21;
      end else if (a11 > a22) begin
         t = (64'sd1 << FB) + a11 - a00 - a22;
         v[0] = a10 + a01; v[1] = t; v[2] = a21 + a12; v[3] = a20 - a02;
      end else begin
         t = (64'sd1 << FB) + a22 - a11 - a00;
         v[0] = a20 + a02; v[1] = a12 + a21; v[2] = t; v[3] = a01 - a10;
      end
      if (t <= 0) begin
         o.qx = '0; o.qy = '0; o.qz = '0; o.qw = '0; o.degen = 1'b1;
         return o;
      end
      mx = 0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? longint'(-v[i]) : v[i];
         if (mag[i] > mx) mx = mag[i];
      end
      // Bring the largest magnitude into [2^29, 2^30).
      while (mx >= (64'd1 << 30)) begin
         for (int i = 0; i < 4; i++) mag[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         for (int i = 0; i < 4; i++) mag[i] <<= 1;
         mx <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
      len = isqrt(sum);
      for (int i = 0; i < 4; i++) begin
         q = (mag[i] * (64'd1 << FB) + (len >> 1)) / len;
         if (q > (64'd1 << (EW - 1)) - 1) q = (64'd1 << (EW - 1)) - 1;
         s = neg[i] ? -longint'(q) : longint'(q);
         r[i] = s[EW-1:0];
      end
      o.qx = r[0]; o.qy = r[1]; o.qz = r[2]; o.qw = r[3]; o.degen = 1'b0;
      return o;
   endfunction

   function automatic elem_type rand_elem();
      case ($urandom_range(0, 5))
         0: return elem_type'($urandom);
         1: return elem_type'(-32768);
         2: return elem_type'(32767);
         default: return elem_type'($urandom_range(0, 2 * (1 << FB)) - (1 << FB));
      endcase
   endfunction

   // Build a near-rotation: rotation about one axis plus small noise.
   function automatic matrix_type rand_rotation();
      matrix_type m;
      real ang, c, s;
      int ax, p, q;
      ang = ($urandom_range(0, 62831) / 10000.0);
      c = $cos(ang) * (1 << FB);
      s = $sin(ang) * (1 << FB);
      ax = $urandom_range(0, 2);
      p = (ax + 1) % 3;
      q = (ax + 2) % 3;
      for (int i = 0; i < 9; i++) m.e[i] = '0;
      m.e[ax*3+ax] = elem_type'(1 << FB);
      m.e[p*3+p] = elem_type'($rtoi(c));
      m.e[q*3+q] = elem_type'($rtoi(c));
      m.e[p*3+q] = elem_type'(-$rtoi(s));
      m.e[q*3+p] = elem_type'($rtoi(s));
      for (int i = 0; i < 9; i++) m.e[i] = m.e[i] + elem_type'($urandom_range(0, 8) - 4);
      return m;
   endfunction

   function automatic matrix_type diag(int d0, int d1, int d2);
      matrix_type m;
      for (int i = 0; i < 9; i++) m.e[i] = '0;
      m.e[0] = elem_type'(d0); m.e[4] = elem_type'(d1); m.e[8] = elem_type'(d2);
      return m;
   endfunction

   // Fill the queue: directed corner matrices first, then random ones.
   initial begin
      matrix_type m;
      int one;
      one = 1 << FB;
      pending_matrices.push_back(diag(one, one, one));          // identity, trace branch
      pending_matrices.push_back(diag(one, -one, -one));        // x largest
      pending_matrices.push_back(diag(-one, one, -one));        // y largest
      pending_matrices.push_back(diag(-one, -one, one));        // z largest
      pending_matrices.push_back(diag(0, 0, 0));                // ties fall to z branch
      pending_matrices.push_back(diag(-32768, -32768, -32768)); // equal diagonal, z branch
      pending_matrices.push_back(diag(-one, -one, -one));
      pending_matrices.push_back(diag(32767, 32767, 32767));
      pending_matrices.push_back(diag(-32768, 32767, -32768));
      for (int k = 0; k < 2; k++) begin
         for (int i = 0; i < 9; i++) m.e[i] = k ? elem_type'(-32768) : elem_type'(32767);
         pending_matrices.push_back(m);
      end
      // Large off-diagonal sum: x branch with two near-equal components.
      m = diag(-32768, -32768, -32768);
      m.e[0] = elem_type'(-16000);
      m.e[1] = elem_type'(32767); m.e[3] = elem_type'(32767);
      pending_matrices.push_back(m);
      m = diag(0, 0, 0);
      m.e[1] = elem_type'(-32768); m.e[3] = elem_type'(32767);
      pending_matrices.push_back(m);
      for (int i = 0; i < 4; i++) pending_matrices.push_back(rand_rotation());
      for (int n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(0, 9) < 7) begin
            m = rand_rotation();
         end else begin
            for (int i = 0; i < 9; i++) m.e[i] = rand_elem();
         end
         pending_matrices.push_back(m);
      end
   end

   // Driver: hold start low for a random gap, then present one beat.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_cycles <= $urandom_range(0, IDLE_MAX);
      end else if (start && !busy) begin
         // Beat taken this edge; predict and decide what follows.
         matrix_type m;
         int gap;
         m.e[0] = req_e00; m.e[1] = req_e01; m.e[2] = req_e02;
         m.e[3] = req_e10; m.e[4] = req_e11; m.e[5] = req_e12;
         m.e[6] = req_e20; m.e[7] = req_e21; m.e[8] = req_e22;
         expected_quats.push_back(matrix_to_quat(m));
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
         if (gap == 0 && pending_matrices.size() > 0) begin
            // no gap: present the next beat right away
            m = pending_matrices.pop_front();
            req_e00 <= m.e[0]; req_e01 <= m.e[1]; req_e02 <= m.e[2];
            req_e10 <= m.e[3]; req_e11 <= m.e[4]; req_e12 <= m.e[5];
            req_e20 <= m.e[6]; req_e21 <= m.e[7]; req_e22 <= m.e[8];
            start <= 1'b1;
         end else begin
            idle_cycles <= (gap > 0) ? gap - 1 : 0;
            start <= 1'b0;
         end
      end else if (!start) begin
         if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
         end else if (pending_matrices.size() > 0) begin
            matrix_type m;
            m = pending_matrices.pop_front();
            req_e00 <= m.e[0]; req_e01 <= m.e[1]; req_e02 <= m.e[2];
            req_e10 <= m.e[3]; req_e11 <= m.e[4]; req_e12 <= m.e[5];
            req_e20 <= m.e[6]; req_e21 <= m.e[7]; req_e22 <= m.e[8];
            start <= 1'b1;
         end else begin
            stimulus_done <= 1'b1;
         end
      end
   end

   // Monitor: compare each result beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         quat_type want;
         if (expected_quats.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_MAX)
               $display("unexpected result beat: %0d %0d %0d %0d degen %0b",
                        rsp_qx, rsp_qy, rsp_qz, rsp_qw, rsp_degenerate);
         end else begin
            want = expected_quats.pop_front();
            if (rsp_qx !== want.qx || rsp_qy !== want.qy || rsp_qz !== want.qz ||
                rsp_qw !== want.qw || rsp_degenerate !== want.degen) begin
               mismatches++;
               if (mismatches <= SHOW_MAX)
                  $display({"mismatch: want %0d %0d %0d %0d degen %0b, ",
                            "got %0d %0d %0d %0d degen %0b"},
                           want.qx, want.qy, want.qz, want.qw, want.degen,
                           rsp_qx, rsp_qy, rsp_qz, rsp_qw, rsp_degenerate);
            end
         end
      end
   end

   // Watchdog: count cycles with no beat in either direction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (!(stimulus_done && expected_quats.size() == 0) && quiet_cycles < STALL_MAX)
         @(posedge clock);
      if (quiet_cycles < STALL_MAX) begin
         repeat (DRAIN) @(posedge clock);
         if (mismatches == 0 && expected_quats.size() == 0) $display("Verification passed");
         else $display("Verification failed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
